// ===== hw/rtl/ppd_pkg.sv =====
package ppd_pkg;

    // Width of the distance result, Q9.8.
    localparam int DIST_BITS = 17;

    // Collinear limit register.
    localparam int LIMIT_WIDTH = 16;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd1;

    // Default coordinate width, Q8.8.
    localparam int COORD_WIDTH_DEF = 16;

    // Register stages ahead of the distance search.
    localparam int PRE_STAGES = 10;

endpackage

// ===== hw/rtl/point_plane_distance.sv =====
// Point to plane distance, fully pipelined.
// Input channel (i_valid / o_ready) carries the three plane points and the query point,
// all signed fixed point. Output channel (o_valid / i_ready) returns the distance
// |n.(Q-P1)| / |n| rounded toward zero, where n = (P2-P1) x (P3-P1), and a collinear flag.
// When |n| is below the collinear limit the flag is set and the distance reads 0.
// The limit is written through i_cfg_wr_en / i_cfg_wr_data; the user must write it
// only while the block is idle, as the block does not enforce this. 10 stages form the
// normal, the plane value and the squared terms, then 17 stages each settle one bit of
// the distance. One transaction per cycle unless a result is held; each stage holds one.
// When the receiver holds i_ready low while a result waits, the whole pipeline holds,
// so nothing is lost or repeated; o_ready then follows i_ready.
// A synchronous reset empties the pipeline and sets the collinear limit to 1,
// so by default only an exactly zero normal counts as collinear.
module point_plane_distance #(
    parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_z,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_z,
    input  logic signed [COORD_WIDTH-1:0]       i_p3_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p3_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p3_z,
    input  logic signed [COORD_WIDTH-1:0]       i_query_x,
    input  logic signed [COORD_WIDTH-1:0]       i_query_y,
    input  logic signed [COORD_WIDTH-1:0]       i_query_z,
    input  logic                                i_cfg_wr_en,
    input  logic [ppd_pkg::LIMIT_WIDTH-1:0]     i_cfg_wr_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ppd_pkg::DIST_BITS-1:0]       o_distance,
    output logic                                o_collinear
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int MW  = 2 * DW;
    localparam int NW  = MW + 1;
    localparam int H   = (NW + 1) / 2;
    localparam int NHW = NW - H;
    localparam int SQW = 2 * NW;
    localparam int SW  = SQW + 2;
    localparam int NQW = NW + DW;
    localparam int PW  = NQW + 2;
    localparam int G   = (PW + 1) / 2;
    localparam int MHW = PW - G;
    localparam int QW  = 2 * PW;
    localparam int DB  = ppd_pkg::DIST_BITS;
    localparam int DPW = SW + DB;
    localparam int EW  = ((QW > SW + 2 * DB + 1) ? QW : SW + 2 * DB + 1) + 1;
    localparam int LW  = ppd_pkg::LIMIT_WIDTH;
    localparam int LAT = ppd_pkg::PRE_STAGES + DB;

    logic en;
    logic [LAT:1] r_vld;

    logic [LW-1:0]   r_lim;
    logic [2*LW-1:0] r_lim2;

    logic signed [CW-1:0] w_p1 [3];
    logic signed [CW-1:0] w_p2 [3];
    logic signed [CW-1:0] w_p3 [3];
    logic signed [CW-1:0] w_pq [3];

    // Stage 1: edge vectors and query offset.
    logic signed [DW-1:0] r_u [3];
    logic signed [DW-1:0] r_v [3];
    logic signed [DW-1:0] r_q1 [3];
    // Stage 2: cross product terms.
    logic signed [MW-1:0] r_m [6];
    logic signed [DW-1:0] r_q2 [3];
    // Stage 3: normal.
    logic signed [NW-1:0] r_n3 [3];
    logic signed [DW-1:0] r_q3 [3];
    // Stage 4: normal magnitude per axis.
    logic [NW-1:0]        r_an [3];
    logic signed [NW-1:0] r_n4 [3];
    logic signed [DW-1:0] r_q4 [3];
    // Stage 5: partial products.
    logic [2*NHW-1:0]         r_shh [3];
    logic [NW-1:0]            r_shl [3];
    logic [2*H-1:0]           r_sll [3];
    logic signed [NHW+DW-1:0] r_nqh [3];
    logic signed [H+DW:0]     r_nql [3];
    // Stage 6: per-axis squares and plane terms.
    logic [SQW-1:0]        r_sq [3];
    logic signed [NQW-1:0] r_nq [3];
    // Stage 7: |n|^2 and plane value.
    logic [SW-1:0]        r_s7;
    logic signed [PW-1:0] r_num;
    // Stage 8: collinear check and magnitude of the plane value.
    logic [SW-1:0] r_s8;
    logic          r_col8;
    logic [PW-1:0] r_mag;
    // Stage 9: partial products of the squared plane value.
    logic [SW-1:0]      r_s9;
    logic               r_col9;
    logic [2*MHW-1:0]   r_mhh;
    logic [PW-1:0]      r_mhl;
    logic [2*G-1:0]     r_mll;

    // Distance search, one bit per stage. Index 0 is the stage 10 output.
    logic [EW-1:0]  r_res [DB+1];
    logic [DPW-1:0] r_dp  [DB+1];
    logic [DB-1:0]  r_d   [DB+1];
    logic [SW-1:0]  r_ss  [DB+1];
    logic           r_cl  [DB+1];

    assign w_p1 = '{i_p1_x, i_p1_y, i_p1_z};
    assign w_p2 = '{i_p2_x, i_p2_y, i_p2_z};
    assign w_p3 = '{i_p3_x, i_p3_y, i_p3_z};
    assign w_pq = '{i_query_x, i_query_y, i_query_z};

    // The pipeline moves as a whole unless a finished result is held.
    assign en      = ~r_vld[LAT] | i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_lim <= ppd_pkg::LIMIT_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-1:1], i_valid};
            end
            if (i_cfg_wr_en) begin
                r_lim <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim2 <= r_lim * r_lim;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k]  <= DW'(w_p2[k]) - DW'(w_p1[k]);
                r_v[k]  <= DW'(w_p3[k]) - DW'(w_p1[k]);
                r_q1[k] <= DW'(w_pq[k]) - DW'(w_p1[k]);
            end

            r_m[0] <= r_u[1] * r_v[2];
            r_m[1] <= r_u[2] * r_v[1];
            r_m[2] <= r_u[2] * r_v[0];
            r_m[3] <= r_u[0] * r_v[2];
            r_m[4] <= r_u[0] * r_v[1];
            r_m[5] <= r_u[1] * r_v[0];
            r_q2   <= r_q1;

            for (int k = 0; k < 3; k++) begin
                r_n3[k] <= NW'(r_m[2*k]) - NW'(r_m[2*k+1]);
            end
            r_q3 <= r_q2;

            for (int k = 0; k < 3; k++) begin
                r_an[k] <= r_n3[k][NW-1] ? NW'(-r_n3[k]) : NW'(r_n3[k]);
            end
            r_n4 <= r_n3;
            r_q4 <= r_q3;

            // Both products are split at bit H so each multiplier stays narrow.
            for (int k = 0; k < 3; k++) begin
                r_shh[k] <= r_an[k][NW-1:H] * r_an[k][NW-1:H];
                r_shl[k] <= r_an[k][NW-1:H] * r_an[k][H-1:0];
                r_sll[k] <= r_an[k][H-1:0] * r_an[k][H-1:0];
                r_nqh[k] <= $signed(r_n4[k][NW-1:H]) * r_q4[k];
                r_nql[k] <= $signed({1'b0, r_n4[k][H-1:0]}) * r_q4[k];
            end

            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (SQW'(r_shh[k]) << (2 * H)) + (SQW'(r_shl[k]) << (H + 1))
                         + SQW'(r_sll[k]);
                r_nq[k] <= (NQW'(r_nqh[k]) <<< H) + NQW'(r_nql[k]);
            end

            r_s7  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_num <= PW'(r_nq[0]) + PW'(r_nq[1]) + PW'(r_nq[2]);

            r_s8   <= r_s7;
            r_col8 <= (r_s7 == '0) || (r_s7 < SW'(r_lim2));
            r_mag  <= r_num[PW-1] ? PW'(-r_num) : PW'(r_num);

            r_s9   <= r_s8;
            r_col9 <= r_col8;
            r_mhh  <= r_mag[PW-1:G] * r_mag[PW-1:G];
            r_mhl  <= r_mag[PW-1:G] * r_mag[G-1:0];
            r_mll  <= r_mag[G-1:0] * r_mag[G-1:0];

            r_res[0] <= EW'((QW'(r_mhh) << (2 * G)) + (QW'(r_mhl) << (G + 1)) + QW'(r_mll));
            r_dp[0]  <= '0;
            r_d[0]   <= '0;
            r_ss[0]  <= r_s9;
            r_cl[0]  <= r_col9;
        end
    end

    // Each stage tries the next lower bit t = d + 2^b. With D = d*s the test
    // t^2*s <= num^2 becomes 2^(b+1)*D + 4^b*s <= num^2 - d^2*s, the residual.
    for (genvar j = 0; j < DB; j++) begin : g_search
        localparam int B = DB - 1 - j;
        logic [EW-1:0] w_step;
        logic          w_take;

        assign w_step = (EW'(r_dp[j]) << (B + 1)) + (EW'(r_ss[j]) << (2 * B));
        assign w_take = (w_step <= r_res[j]);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_res[j+1] <= w_take ? (r_res[j] - w_step) : r_res[j];
                r_dp[j+1]  <= w_take ? (r_dp[j] + (DPW'(r_ss[j]) << B)) : r_dp[j];
                r_d[j+1]   <= w_take ? (r_d[j] | (DB'(1) << B)) : r_d[j];
                r_ss[j+1]  <= r_ss[j];
                r_cl[j+1]  <= r_cl[j];
            end
        end
    end

    assign o_valid     = r_vld[LAT];
    assign o_collinear = r_cl[DB];
    assign o_distance  = r_cl[DB] ? '0 : r_d[DB];

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_vld[LAT] && !i_ready))
        else $error("pipeline stalled without a held result");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[1])
        else $error("accepted transaction did not enter the pipeline");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_distance) && $stable(o_collinear)))
        else $error("held result changed");

    a_limit_reset: assert property (@(posedge i_clk)
        (!i_rst_n) |=> (r_lim == ppd_pkg::LIMIT_RESET))
        else $error("collinear limit not restored by reset");

endmodule
